FILE: sv/fhcs_pkg.sv
// shared types, constants and crc helpers for the frame header crc sealer
package fhcs_pkg;

  localparam logic [7:0]  SOF_RESET       = 8'hA5;
  localparam logic [7:0]  CRC8_SEED       = 8'hFF;
  localparam logic [15:0] CRC16_SEED      = 16'hFFFF;
  localparam logic [7:0]  CRC8_POLY_REFL  = 8'h8C;
  localparam logic [15:0] CRC16_POLY_REFL = 16'h8408;
  localparam int          BYTE_W          = 8;
  localparam int          LEN_W           = 10;

  // position of the byte being emitted within the item's run
  typedef enum logic [2:0] {
    PH_SOF,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_SEQ,
    PH_CRC8,
    PH_BODY,
    PH_CRC_LO,
    PH_CRC_HI
  } phase_t;

  // one emitted byte with its markers
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              run_end;
    logic              frame_end;
  } emit_t;

  // reflected maxim crc-8, one byte
  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC8_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

  // reflected 0x8408 crc-16, one byte
  function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC16_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: sv/fhcs_framer.sv
// item register, byte sequencer and running crc state of the sealer
module fhcs_framer
  import fhcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] body_byte,
  input  logic              first_of_frame,
  input  logic              last_of_frame,
  input  logic [LEN_W-1:0]  payload_length,
  input  logic [BYTE_W-1:0] sof_byte,
  output logic              emit_valid,
  input  logic              emit_ready,
  output emit_t             emit
);

  logic              work_valid_r, work_valid_nxt;
  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] body_r;
  logic              last_r;
  logic [LEN_W-1:0]  len_r;
  logic [7:0]        crc8_r, crc8_nxt;
  logic [15:0]       crc16_r, crc16_nxt;
  logic [7:0]        seq_r, seq_nxt;

  logic              emit_fire;
  logic              run_done;
  logic              load;
  logic [BYTE_W-1:0] cur_byte;

  // handshake between the item register and the result side
  assign emit_valid = work_valid_r;
  assign emit_fire  = work_valid_r && emit_ready;
  assign run_done   = emit_fire &&
                      (((phase_r == PH_BODY) && !last_r) || (phase_r == PH_CRC_HI));
  assign in_ready   = !work_valid_r || run_done;
  assign load       = in_valid && in_ready;

  // byte selection for the current phase
  always_comb begin
    case (phase_r)
      PH_SOF:    cur_byte = sof_byte;
      PH_LEN_LO: cur_byte = len_r[7:0];
      PH_LEN_HI: cur_byte = {{(2*BYTE_W-LEN_W){1'b0}}, len_r[LEN_W-1:BYTE_W]};
      PH_SEQ:    cur_byte = seq_r;
      PH_CRC8:   cur_byte = crc8_r;
      PH_BODY:   cur_byte = body_r;
      PH_CRC_LO: cur_byte = crc16_r[7:0];
      PH_CRC_HI: cur_byte = crc16_r[15:8];
      default:   cur_byte = body_r;
    endcase
  end

  assign emit.out_byte  = cur_byte;
  assign emit.run_end   = ((phase_r == PH_BODY) && !last_r) || (phase_r == PH_CRC_HI);
  assign emit.frame_end = (phase_r == PH_CRC_HI);

  // phase sequencing and crc / sequence updates
  always_comb begin
    work_valid_nxt = work_valid_r;
    phase_nxt      = phase_r;
    crc8_nxt       = crc8_r;
    crc16_nxt      = crc16_r;
    seq_nxt        = seq_r;
    if (emit_fire) begin
      case (phase_r)
        PH_SOF: begin
          phase_nxt = PH_LEN_LO;
          crc8_nxt  = crc8_fold(CRC8_SEED, cur_byte);
          crc16_nxt = crc16_fold(CRC16_SEED, cur_byte);
        end
        PH_LEN_LO: begin
          phase_nxt = PH_LEN_HI;
          crc8_nxt  = crc8_fold(crc8_r, cur_byte);
          crc16_nxt = crc16_fold(crc16_r, cur_byte);
        end
        PH_LEN_HI: begin
          phase_nxt = PH_SEQ;
          crc8_nxt  = crc8_fold(crc8_r, cur_byte);
          crc16_nxt = crc16_fold(crc16_r, cur_byte);
        end
        PH_SEQ: begin
          phase_nxt = PH_CRC8;
          crc8_nxt  = crc8_fold(crc8_r, cur_byte);
          crc16_nxt = crc16_fold(crc16_r, cur_byte);
        end
        PH_CRC8: begin
          phase_nxt = PH_BODY;
          crc16_nxt = crc16_fold(crc16_r, cur_byte);
        end
        PH_BODY: begin
          crc16_nxt = crc16_fold(crc16_r, cur_byte);
          if (last_r) begin
            phase_nxt = PH_CRC_LO;
          end else begin
            work_valid_nxt = 1'b0;
          end
        end
        PH_CRC_LO: begin
          phase_nxt = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          crc16_nxt      = CRC16_SEED;
          seq_nxt        = seq_r + 8'd1;
          work_valid_nxt = 1'b0;
        end
        default: begin
          work_valid_nxt = 1'b0;
        end
      endcase
    end
    // a new item takes over the register as the old one finishes
    if (load) begin
      work_valid_nxt = 1'b1;
      phase_nxt      = first_of_frame ? PH_SOF : PH_BODY;
    end
  end

  // control and crc state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_valid_r <= 1'b0;
      phase_r      <= PH_BODY;
      crc8_r       <= CRC8_SEED;
      crc16_r      <= CRC16_SEED;
      seq_r        <= 8'h00;
    end else begin
      work_valid_r <= work_valid_nxt;
      phase_r      <= phase_nxt;
      crc8_r       <= crc8_nxt;
      crc16_r      <= crc16_nxt;
      seq_r        <= seq_nxt;
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (load) begin
      body_r <= body_byte;
      last_r <= last_of_frame;
      len_r  <= payload_length;
    end
  end

endmodule

FILE: sv/frame_header_crc_sealer_top.sv
// top level of the frame header crc sealer: config register, framer and output register
//
//  channel | direction | handshake              | payload
//  in_     | in        | in_tvalid / in_tready  | tdata body+length, tuser first, tlast last
//  out_    | out       | out_tvalid / out_tready| tdata byte, tuser run end, tlast frame end
//  cfg_    | in        | cfg_valid / cfg_ready  | cfg_data start-of-frame byte
//
// one output byte per cycle if out_tready is high: an item is 1 byte, 6 if it opens a
// frame, 2 more if it closes one; the single byte-wide output register sets this pace.
// the next item is accepted in the cycle its predecessor's last byte leaves the framer.
// synchronous active-low reset, no clearing pass; cfg_ready is always high.
// out_tready low holds the output register and, through it, the framer and input.
module frame_header_crc_sealer_top
  import fhcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] body_byte, [17:8] payload_length, [23:18] zero
  input  logic        in_tuser,   // [0] first_of_frame
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tuser,  // [0] run_end
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic [7:0] sof_r;
  logic       emit_valid;
  logic       emit_ready;
  emit_t      emit;
  logic       out_valid_r;
  emit_t      out_r;

  // start-of-frame register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sof_r <= SOF_RESET;
    end else if (cfg_valid) begin
      sof_r <= cfg_data;
    end
  end

  fhcs_framer u_framer (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .body_byte      (in_tdata[7:0]),
    .first_of_frame (in_tuser),
    .last_of_frame  (in_tlast),
    .payload_length (in_tdata[17:8]),
    .sof_byte       (sof_r),
    .emit_valid     (emit_valid),
    .emit_ready     (emit_ready),
    .emit           (emit)
  );

  // output register
  assign emit_ready = !out_valid_r || out_tready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_ready) begin
      out_valid_r <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ready && emit_valid) begin
      out_r <= emit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.out_byte;
  assign out_tuser  = out_r.run_end;
  assign out_tlast  = out_r.frame_end;

`ifndef NO_ASSERTIONS
  // a frame always closes on the last byte of its item
  a_frame_end_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("frame end without run end");

  // an accepted item always yields a byte from the framer next cycle
  a_load_gives_emit: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> emit_valid)
    else $error("accepted item produced no byte");

  // a byte moved out of the framer shows up at the output
  a_emit_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    emit_valid && emit_ready |=> out_tvalid)
    else $error("emitted byte lost");

  // input is taken only when the framer is empty or finishing its item
  a_ready_when_finishing: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && emit_valid |-> emit_ready && emit.run_end)
    else $error("input ready while framer busy");
`endif

endmodule

FILE: tb/frame_header_crc_sealer_top_tb.sv
// testbench for the frame header crc sealer: directed table, random frames, scoreboard
module frame_header_crc_sealer_top_tb
  import fhcs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 16;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  // one row of the directed table; lit_byte is the typed-in result of a plain body byte
  typedef struct {
    logic [7:0] body;
    logic       first;
    logic       last;
    logic [9:0] len;
    bit         typed;
    logic [7:0] lit_byte;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;  // [7:0] body_byte, [17:8] payload_length, [23:18] zero
  logic        in_tuser = 1'b0;  // [0] first_of_frame
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [7:0]  out_tdata;  // [7:0] out_byte
  logic        out_tuser;  // [0] run_end
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  idle_mode_t idle_mode = IDLE_NONE;

  // sealer state as predicted
  logic [7:0]  sof_model = SOF_RESET;
  logic [7:0]  seq_model = 8'h00;
  logic [15:0] link_crc = CRC16_SEED;
  emit_t       run_buf [8];

  // frame bytes still owed by the block, oldest first
  emit_t frame_bytes_due [$];

  int errors = 0;
  int items_sent = 0;
  int bytes_checked = 0;
  int frames_closed = 0;
  int cfg_writes = 0;
  int cycle_count = 0;

  frame_header_crc_sealer_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // header crc-8, bit-serial, lsb first
  function automatic logic [7:0] crc8_byte(input logic [7:0] c, input logic [7:0] d);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ d[i];
      c = c >> 1;
      if (fb) c = c ^ CRC8_POLY_REFL;
    end
    return c;
  endfunction

  // frame crc-16, bit-serial, lsb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] d);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ d[i];
      c = c >> 1;
      if (fb) c = c ^ CRC16_POLY_REFL;
    end
    return c;
  endfunction

  // put one byte on the predicted wire and fold it into the frame crc
  function automatic int emit_folded(input int n, input logic [7:0] b);
    run_buf[n] = '{b, 1'b0, 1'b0};
    link_crc = crc16_byte(link_crc, b);
    return n + 1;
  endfunction

  // bytes one input item puts on the wire; returns their count
  function automatic int seal_item(input logic [7:0] body, input logic first,
                                   input logic last, input logic [9:0] len);
    logic [7:0]  hdr [4];
    logic [7:0]  c8;
    logic [15:0] trailer;
    int          n;
    n = 0;
    // header: sof, length low/high, sequence, crc-8
    if (first) begin
      hdr[0] = sof_model;
      hdr[1] = len[7:0];
      hdr[2] = {6'b0, len[9:8]};
      hdr[3] = seq_model;
      link_crc = CRC16_SEED;
      c8 = CRC8_SEED;
      for (int i = 0; i < 4; i++) begin
        c8 = crc8_byte(c8, hdr[i]);
        n = emit_folded(n, hdr[i]);
      end
      n = emit_folded(n, c8);
    end
    n = emit_folded(n, body);
    // trailer: crc-16 low then high, closes the frame
    if (last) begin
      trailer = link_crc;
      run_buf[n] = '{trailer[7:0], 1'b0, 1'b0};
      run_buf[n + 1] = '{trailer[15:8], 1'b0, 1'b1};
      n = n + 2;
      seq_model = seq_model + 8'd1;
      link_crc = CRC16_SEED;
    end
    run_buf[n - 1].run_end = 1'b1;
    return n;
  endfunction

  function automatic bit draw_stall(input idle_mode_t heavy);
    if (idle_mode == heavy) return $urandom_range(0, 99) < 73;
    if (idle_mode == IDLE_BOTH) return $urandom_range(0, 99) < 20;
    return 1'b0;
  endfunction

  // receiver back-pressure
  always @(negedge clk) begin
    out_tready <= !draw_stall(IDLE_RECV);
  end

  // send one item, entered and left at a falling edge
  task automatic send_item(input logic [7:0] body, input logic first, input logic last,
                           input logic [9:0] len, input bit typed, input logic [7:0] lit);
    int n;
    while (draw_stall(IDLE_SEND)) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, len, body};
    in_tuser <= first;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n = seal_item(body, first, last, len);
    if (typed) begin
      frame_bytes_due.push_back('{lit, 1'b1, 1'b0});
    end else begin
      for (int i = 0; i < n; i++) frame_bytes_due.push_back(run_buf[i]);
    end
    items_sent++;
    @(negedge clk);
  endtask

  // start-of-frame register write, only with the block drained
  task automatic write_sof(input logic [7:0] value);
    in_tvalid <= 1'b0;
    while (frame_bytes_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sof_model = value;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly whole frames with random content, some stray items
  task automatic random_items(input int target);
    int         sent;
    int         blen;
    logic [9:0] len;
    sent = 0;
    while (sent < target) begin
      len = 10'($urandom_range(0, 1023));
      if ($urandom_range(0, 9) < 8) begin
        blen = $urandom_range(1, 6);
        for (int k = 0; k < blen; k++) begin
          send_item(8'($urandom), k == 0, k == blen - 1, len, 1'b0, 8'h00);
        end
        sent += blen;
      end else begin
        send_item(8'($urandom), 1'($urandom), 1'($urandom), len, 1'b0, 8'h00);
        sent++;
      end
    end
  endtask

  function automatic void check_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endfunction

  // scoreboard on the result channel
  always @(posedge clk) begin
    emit_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (frame_bytes_due.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected byte, expected none, actual %h", $time, out_tdata);
      end else begin
        want = frame_bytes_due.pop_front();
        check_field("out_byte", want.out_byte, out_tdata);
        check_field("run_end", {7'b0, want.run_end}, {7'b0, out_tuser});
        check_field("frame_end", {7'b0, want.frame_end}, {7'b0, out_tlast});
        bytes_checked++;
        if (out_tlast === 1'b1) frames_closed++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // directed table: stray byte after reset, extremes of length and body, dropped frame
  stim_row_t directed [] = '{
    '{8'h3C, 1'b0, 1'b0, 10'h000, 1'b1, 8'h3C},
    '{8'h00, 1'b1, 1'b1, 10'h000, 1'b0, 8'h00},
    '{8'hFF, 1'b1, 1'b0, 10'h3FF, 1'b0, 8'h00},
    '{8'h55, 1'b0, 1'b0, 10'h000, 1'b1, 8'h55},
    '{8'hAA, 1'b0, 1'b0, 10'h000, 1'b1, 8'hAA},
    '{8'h81, 1'b0, 1'b1, 10'h000, 1'b0, 8'h00},
    '{8'h12, 1'b1, 1'b0, 10'h200, 1'b0, 8'h00},
    '{8'h34, 1'b0, 1'b0, 10'h000, 1'b1, 8'h34},
    '{8'h56, 1'b1, 1'b0, 10'h155, 1'b0, 8'h00},
    '{8'h78, 1'b0, 1'b1, 10'h000, 1'b0, 8'h00},
    '{8'h9A, 1'b0, 1'b1, 10'h2AA, 1'b0, 8'h00},
    '{8'hFF, 1'b1, 1'b1, 10'h3FF, 1'b0, 8'h00},
    '{8'h00, 1'b0, 1'b0, 10'h3FF, 1'b1, 8'h00},
    '{8'h01, 1'b1, 1'b0, 10'h0FF, 1'b0, 8'h00},
    '{8'hFE, 1'b0, 1'b0, 10'h000, 1'b1, 8'hFE},
    '{8'h7F, 1'b0, 1'b1, 10'h100, 1'b0, 8'h00}
  };

  // main sequence
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed rows at the reset start byte, no idling
    foreach (directed[r]) begin
      send_item(directed[r].body, directed[r].first, directed[r].last, directed[r].len,
                directed[r].typed, directed[r].lit_byte);
    end

    // random phases, each with its own start byte and idling
    write_sof(8'h00);
    idle_mode = IDLE_NONE;
    random_items(22);
    write_sof(8'hFF);
    idle_mode = IDLE_SEND;
    random_items(22);
    write_sof(8'($urandom));
    idle_mode = IDLE_RECV;
    random_items(22);
    write_sof(SOF_RESET);
    idle_mode = IDLE_BOTH;
    random_items(22);

    in_tvalid <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items, %0d bytes checked, %0d frames sealed, %0d start-byte writes",
             items_sent, bytes_checked, frames_closed, cfg_writes);
    $display("idling phases: none, sender gaps, receiver stalls, both; %0d mismatches",
             errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
